[hw/rtl/tlfs_pkg.sv]
// Shared constants, types and codes for the two-level feedback scheduler.
`timescale 1ns / 1ps
package tlfs_pkg;

	localparam int MAX_TASKS     = 16;
	localparam int TIME_BITS     = 16;
	localparam int ID_SLOTS      = 16;
	localparam int ID_W          = 4;
	localparam int RUN_W         = 16;
	localparam int RES_W         = 4;
	localparam int QNT_W         = 4;
	localparam int CNT_W         = 5;
	localparam int Q_AW          = $clog2(MAX_TASKS);
	localparam int FILL_W        = $clog2(MAX_TASKS + 1);
	localparam int TBL_AW        = $clog2(ID_SLOTS);
	localparam int PADDR_W       = 2;
	localparam int PDATA_W       = 32;

	localparam logic [QNT_W-1:0]   QUANTUM_RESET = QNT_W'(3);
	localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
	localparam logic [PADDR_W-1:0] ADDR_QUANTUM  = PADDR_W'(0);

	localparam logic ACT_ARRIVAL = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	typedef logic [ID_W-1:0]      task_id_t;
	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		time_t             need;
		time_t             used;
		logic [RES_W-1:0]  res;
	} tbl_entry_t;

	localparam int TBL_W = $bits(tbl_entry_t);

	typedef struct packed {
		logic     push;
		logic     pop;
		task_id_t push_id;
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

[hw/rtl/tlfs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tlfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/tlfs_fifo.sv]
// Task-id FIFO: head/fill pointers around a RAM, with pop-after-push forwarding.
`timescale 1ns / 1ps
module tlfs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_req,
	input  tlfs_pkg::fifo_ctl_t ctl,
	output tlfs_pkg::fifo_st_t  st,
	output tlfs_pkg::task_id_t  pop_id
);
	import tlfs_pkg::*;

	logic [Q_AW-1:0]   head_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W:0]   wsum;
	logic [Q_AW-1:0]   waddr;
	task_id_t          rdata;

	assign st.full  = (fill_q == FILL_W'(MAX_TASKS));
	assign st.empty = (fill_q == '0);

	assign wsum  = (FILL_W + 1)'(head_q) + (FILL_W + 1)'(fill_q);
	assign waddr = (wsum >= (FILL_W + 1)'(MAX_TASKS)) ?
		Q_AW'(wsum - (FILL_W + 1)'(MAX_TASKS)) : Q_AW'(wsum);

	// an entry pushed into an empty queue is popped in the same cycle
	assign pop_id = st.empty ? ctl.push_id : rdata;

	tlfs_ram #(
		.WIDTH ($bits(task_id_t)),
		.DEPTH (MAX_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (waddr),
		.wdata (ctl.push_id),
		.re    (rd_req),
		.raddr (head_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= (head_q == Q_AW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;
			end
			unique case ({ctl.push, ctl.pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[hw/rtl/two_level_feedback_scheduler.sv]
// Top level: request sequencer, task time table and the two task FIFOs.
// Sequence: an accepted request is registered into the execute state, and done is registered from that state.
// Requests are not accepted while busy (execute state); the read-modify-write of the task table
// and queue RAMs is a registered read on acceptance followed by the update in the execute state.
// Reset: queue pointers, CPU state and finished count clear; quantum returns to 3.
// RAM contents are not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps
module two_level_feedback_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [tlfs_pkg::ID_W-1:0]         task_id,
	input  logic [tlfs_pkg::RUN_W-1:0]        run_length,
	output logic                              done,
	output logic                              running_valid,
	output logic [tlfs_pkg::ID_W-1:0]         running_task,
	output logic                              finished_valid,
	output logic [tlfs_pkg::ID_W-1:0]         finished_task,
	output logic                              preempted,
	output logic                              picked_from_low,
	output logic                              dropped,
	output logic [tlfs_pkg::CNT_W-1:0]        finished_count,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tlfs_pkg::PADDR_W-1:0]      paddr,
	input  logic [tlfs_pkg::PDATA_W-1:0]      pwdata,
	output logic [tlfs_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import tlfs_pkg::*;

	state_t            state_q;
	logic              accept;
	logic              exec;

	logic              action_q;
	task_id_t          id_q;
	time_t             len_q;

	logic [QNT_W-1:0]  quantum_q;
	logic              cpu_busy_q;
	task_id_t          cpu_task_q;
	logic [CNT_W-1:0]  done_total_q;

	logic              done_q;
	logic              fin_q;
	task_id_t          fin_id_q;
	logic              pre_q;
	logic              from_low_q;
	logic              drop_q;

	fifo_ctl_t         hi_ctl;
	fifo_ctl_t         lo_ctl;
	fifo_st_t          hi_st;
	fifo_st_t          lo_st;
	task_id_t          hi_pop_id;
	task_id_t          lo_pop_id;

	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	tbl_entry_t        tbl_wdata;
	logic [TBL_W-1:0]  tbl_rraw;
	tbl_entry_t        tbl_rd;

	time_t             used_inc;
	logic [RES_W:0]    res_inc;
	logic              fin;
	logic              pre;
	logic              pick;
	logic              drop;
	logic              from_low;
	logic              busy_nx;
	task_id_t          task_nx;

	assign exec   = (state_q == ST_EXEC);
	assign busy   = exec;
	assign accept = start && !busy;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_QUANTUM) ? PDATA_W'(quantum_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_QUANTUM)) begin
			quantum_q <= pwdata[QNT_W-1:0];
		end
	end

	tlfs_fifo u_high (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (accept),
		.ctl    (hi_ctl),
		.st     (hi_st),
		.pop_id (hi_pop_id)
	);

	tlfs_fifo u_low (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (accept),
		.ctl    (lo_ctl),
		.st     (lo_st),
		.pop_id (lo_pop_id)
	);

	tlfs_ram #(
		.WIDTH (TBL_W),
		.DEPTH (ID_SLOTS)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (accept),
		.raddr (TBL_AW'(cpu_task_q)),
		.rdata (tbl_rraw)
	);

	assign tbl_rd   = tbl_entry_t'(tbl_rraw);
	assign used_inc = tbl_rd.used + 1'b1;
	assign res_inc  = (RES_W + 1)'(tbl_rd.res) + 1'b1;

	always_comb begin
		hi_ctl    = '0;
		lo_ctl    = '0;
		tbl_we    = 1'b0;
		tbl_waddr = TBL_AW'(cpu_task_q);
		tbl_wdata = tbl_rd;
		fin       = 1'b0;
		pre       = 1'b0;
		pick      = 1'b0;
		drop      = 1'b0;
		from_low  = 1'b0;
		busy_nx   = cpu_busy_q;
		task_nx   = cpu_task_q;
		hi_ctl.push_id = id_q;
		lo_ctl.push_id = cpu_task_q;
		if (action_q == ACT_ARRIVAL) begin
			if (hi_st.full) begin
				drop = 1'b1;
			end else begin
				hi_ctl.push = exec;
				tbl_we      = exec;
				tbl_waddr   = TBL_AW'(id_q);
				tbl_wdata   = '{need: len_q, used: '0, res: '0};
			end
		end else begin
			pick = !cpu_busy_q;
			if (cpu_busy_q) begin
				tbl_we         = exec;
				tbl_wdata.used = used_inc;
				if (used_inc == tbl_rd.need) begin
					fin  = 1'b1;
					pick = 1'b1;
				end else if (res_inc >= (RES_W + 1)'(quantum_q)) begin
					tbl_wdata.res = '0;
					pre           = 1'b1;
					pick          = 1'b1;
					lo_ctl.push   = exec && !lo_st.full;
					drop          = lo_st.full;
				end else begin
					tbl_wdata.res = res_inc[RES_W-1:0];
				end
			end
			if (pick) begin
				if (!hi_st.empty) begin
					hi_ctl.pop = exec;
					busy_nx    = 1'b1;
					task_nx    = hi_pop_id;
				end else if (!lo_st.empty || lo_ctl.push) begin
					lo_ctl.pop = exec;
					busy_nx    = 1'b1;
					task_nx    = lo_pop_id;
					from_low   = 1'b1;
				end else begin
					busy_nx    = 1'b0;
					task_nx    = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			id_q     <= task_id;
			len_q    <= time_t'(run_length);
		end
		if (exec) begin
			fin_q      <= fin;
			fin_id_q   <= fin ? cpu_task_q : '0;
			pre_q      <= pre;
			from_low_q <= from_low;
			drop_q     <= drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			cpu_busy_q   <= 1'b0;
			cpu_task_q   <= '0;
			done_total_q <= '0;
		end else begin
			done_q <= exec;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q    <= ST_IDLE;
					cpu_busy_q <= busy_nx;
					cpu_task_q <= task_nx;
					if (fin && (done_total_q != CNT_MAX)) begin
						done_total_q <= done_total_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign running_valid   = cpu_busy_q;
	assign running_task    = cpu_busy_q ? cpu_task_q : '0;
	assign finished_valid  = fin_q;
	assign finished_task   = fin_id_q;
	assign preempted       = pre_q;
	assign picked_from_low = from_low_q;
	assign dropped         = drop_q;
	assign finished_count  = done_total_q;

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execute state held more than one cycle");

	a_result_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle without result strobe");

	a_fin_pre_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(finished_valid && preempted))
		else $error("task both finished and preempted");

	a_low_pick_runs: assert property (@(posedge clk) disable iff (!arst_n)
		done && picked_from_low |-> running_valid)
		else $error("low queue pick left CPU idle");

endmodule
